/* design/acma_pkg.sv */
// Shared types and constants for the ADC current moving-average unit.
package acma_pkg;

    // Window length of the boxcar average; must be a power of two.
    localparam int WINDOW = 16;
    localparam int WIN_BITS = $clog2(WINDOW);
    localparam int SAMPLE_W = 16;
    localparam int SUM_W = SAMPLE_W + WIN_BITS;
    localparam int RESULT_W = 17;
    localparam int BYTE_W = 8;

    // One converter read as it travels from the input register to the core.
    typedef struct packed {
        logic [BYTE_W-1:0] code_high;
        logic [BYTE_W-1:0] code_low;
        logic              read_failed;
    } t_item;

endpackage

/* design/acma_in_reg.sv */
// Input register that holds one accepted converter read for the core.
module acma_in_reg
    import acma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_code_high,
    input  logic [BYTE_W-1:0] i_code_low,
    input  logic              i_read_failed,
    input  logic              i_take,
    output logic              o_valid,
    output t_item             o_item
);

    logic  r_valid;
    t_item r_item;
    logic  load;

    // The register takes a new item when it is empty or its item moves on.
    assign o_in_stall = r_valid && !i_take;
    assign load       = i_in_valid && !o_in_stall;

    // Valid flag of the held item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload of the held item.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.code_high   <= i_code_high;
            r_item.code_low    <= i_code_low;
            r_item.read_failed <= i_read_failed;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* design/acma_core.sv */
// Sample ring, running sum and result register of the moving average.
module acma_core
    import acma_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  t_item                      i_item,
    input  logic signed [SAMPLE_W-1:0] i_offset,
    output logic                       o_take,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [RESULT_W-1:0] o_current_value,
    output logic                       o_error_flag
);

    logic signed [SAMPLE_W-1:0] r_ring [WINDOW];
    logic signed [SUM_W-1:0]    r_sum;
    logic [WIN_BITS-1:0]        r_pos;
    logic signed [SAMPLE_W-1:0] r_last;
    logic                       r_out_valid;
    logic signed [RESULT_W-1:0] r_value;
    logic                       r_error;

    logic                       take;
    logic                       good;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] oldest;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SUM_W-1:0]    biased;
    logic signed [SAMPLE_W-1:0] average;
    logic signed [SAMPLE_W-1:0] base;
    logic signed [RESULT_W-1:0] n_value;

    // The core moves an item on when the result register is free or draining.
    assign take   = i_valid && (!r_out_valid || !i_out_stall);
    assign o_take = take;
    assign good   = take && !i_item.read_failed;

    // Subtracting midscale from an offset-binary code flips its top bit.
    assign sample = {~i_item.code_high[BYTE_W-1], i_item.code_high[BYTE_W-2:0],
                     i_item.code_low};
    assign oldest = r_ring[r_pos];

    // Running sum update and division toward zero by the window length.
    always_comb begin
        n_sum  = r_sum + SUM_W'(sample) - SUM_W'(oldest);
        biased = n_sum[SUM_W-1] ? n_sum + SUM_W'(WINDOW - 1) : n_sum;
        average = SAMPLE_W'(biased >>> WIN_BITS);
        base    = i_item.read_failed ? r_last : average;
        n_value = RESULT_W'(base) + RESULT_W'(i_offset);
    end

    // Filter state: ring, sum, position and the last good sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
            r_sum  <= '0;
            r_pos  <= '0;
            r_last <= '0;
        end else if (good) begin
            r_ring[r_pos] <= sample;
            r_sum         <= n_sum;
            r_pos         <= r_pos + WIN_BITS'(1);
            r_last        <= sample;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_value <= n_value;
            r_error <= i_item.read_failed;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_current_value = r_value;
    assign o_error_flag    = r_error;

`ifndef NO_ASSERTIONS
    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !r_out_valid)
        else $error("result valid after reset");

    // A failed read leaves the running sum and held sample untouched.
    a_fail_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_item.read_failed |=> $stable(r_sum) && $stable(r_last))
        else $error("failed read changed filter state");

    // A good read advances the ring position by one.
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        good |=> r_pos == $past(r_pos) + WIN_BITS'(1))
        else $error("ring position did not advance");

    // Every item taken yields a pending result in the next cycle.
    a_take_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_out_valid)
        else $error("item taken without a result");
`endif

endmodule

/* design/adc_current_moving_average_unit.sv */
// An item accepted into the input register moves on to the result register when that
// register is free or its result is taken in the same cycle.
// Throughput: one item per cycle while the output is not stalled; the input register
// and result register each hold one item.
// Reset (synchronous, active low) clears the sample ring, running sum, ring
// position, held sample and calibration offset, and empties both registers.
// Top level of the ADC current moving-average unit.
module adc_current_moving_average_unit
    import acma_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [BYTE_W-1:0]          i_code_high,
    input  logic [BYTE_W-1:0]          i_code_low,
    input  logic                       i_read_failed,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [RESULT_W-1:0] o_current_value,
    output logic                       o_error_flag,
    input  logic                       i_cfg_we,
    input  logic signed [SAMPLE_W-1:0] i_cfg_wdata
);

    logic signed [SAMPLE_W-1:0] r_current_offset;
    logic                       item_valid;
    logic                       take;
    t_item                      item;

    // Calibration offset register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_offset <= '0;
        end else if (i_cfg_we) begin
            r_current_offset <= i_cfg_wdata;
        end
    end

    acma_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_code_high   (i_code_high),
        .i_code_low    (i_code_low),
        .i_read_failed (i_read_failed),
        .i_take        (take),
        .o_valid       (item_valid),
        .o_item        (item)
    );

    acma_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (item_valid),
        .i_item          (item),
        .i_offset        (r_current_offset),
        .o_take          (take),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_current_value (o_current_value),
        .o_error_flag    (o_error_flag)
    );

endmodule

/* sim/tb_adc_current_moving_average_unit.sv */
// Self-checking testbench for the ADC current moving-average unit.
`timescale 1ns / 1ps

module tb_adc_current_moving_average_unit;
    import acma_pkg::*;

    localparam int CODE_MIDSCALE = 32768;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_OFF_CYCLES = 40;

    // One expected filter output.
    typedef struct {
        logic signed [RESULT_W-1:0] value;
        logic                       err;
    } t_reading_result;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [BYTE_W-1:0]          code_high;
    logic [BYTE_W-1:0]          code_low;
    logic                       read_failed;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [RESULT_W-1:0] current_value;
    logic                       error_flag;
    logic                       cfg_we;
    logic signed [SAMPLE_W-1:0] cfg_wdata;

    // Filter state as the testbench tracks it.
    logic signed [SAMPLE_W-1:0] sample_history [WINDOW];
    int                         window_total;
    logic [WIN_BITS-1:0]        oldest_slot;
    logic signed [SAMPLE_W-1:0] held_sample;
    logic signed [SAMPLE_W-1:0] cal_offset;

    t_reading_result expected_readings [$];
    int              mismatch_count = 0;

    // Idle controls shared between the test tasks and the receiver.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit idle_allowed = 1'b1;
    int rx_hold_cycles = 0;

    adc_current_moving_average_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_code_high     (code_high),
        .i_code_low      (code_low),
        .i_read_failed   (read_failed),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_current_value (current_value),
        .o_error_flag    (error_flag),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offers one item until it is accepted, then updates the filter state.
    task automatic send_reading(input t_item rd);
        int              gap;
        int              sample;
        t_reading_result res;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        code_high   <= rd.code_high;
        code_low    <= rd.code_low;
        read_failed <= rd.read_failed;
        do @(posedge clk); while (in_stall);

        // A good read enters the window; a failed one reports the held sample.
        if (!rd.read_failed) begin
            sample = int'({rd.code_high, rd.code_low}) - CODE_MIDSCALE;
            window_total = window_total + sample - sample_history[oldest_slot];
            sample_history[oldest_slot] = sample[SAMPLE_W-1:0];
            oldest_slot = oldest_slot + WIN_BITS'(1);
            held_sample = sample[SAMPLE_W-1:0];
            res.value = RESULT_W'(window_total / WINDOW + cal_offset);
            res.err = 1'b0;
        end else begin
            res.value = RESULT_W'(int'(held_sample) + int'(cal_offset));
            res.err = 1'b1;
        end
        expected_readings.push_back(res);
    endtask

    // Stops offering and waits until every expected result is out.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the calibration offset once the block is idle.
    task automatic write_offset(input logic signed [SAMPLE_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        cal_offset = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Draws one read, biased toward the code extremes and midscale.
    function automatic t_item random_reading();
        t_item rd;
        int    pick;
        rd.code_high = 8'($urandom);
        rd.code_low  = 8'($urandom);
        pick = $urandom_range(0, 9);
        case (pick)
            0: begin
                {rd.code_high, rd.code_low} = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            1: begin
                {rd.code_high, rd.code_low} = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            end
            2: begin
                rd.code_high = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
            end
            default: begin
            end
        endcase
        rd.read_failed = ($urandom_range(0, 9) == 0);
        return rd;
    endfunction

    // Failed reads before any good read report the offset alone.
    task automatic test_failed_read_before_samples();
        send_reading('{8'h00, 8'h00, 1'b1});
        write_offset(16'sd1234);
        send_reading('{8'hFF, 8'hFF, 1'b1});
    endtask

    // Code extremes at both offset extremes, including a fully filled window.
    task automatic test_code_extremes();
        int i;
        write_offset(16'sh7FFF);
        send_reading('{8'hFF, 8'hFF, 1'b0});
        send_reading('{8'h00, 8'h00, 1'b0});
        send_reading('{8'h80, 8'h00, 1'b0});
        send_reading('{8'h7F, 8'hFF, 1'b0});
        send_reading('{8'h80, 8'h01, 1'b0});
        send_reading('{8'h5A, 8'hA5, 1'b1});
        write_offset(16'sh8000);
        for (i = 0; i < WINDOW; i++) begin
            send_reading('{8'h00, 8'h00, 1'b0});
        end
        send_reading('{8'hC3, 8'h3C, 1'b1});
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_output_hold_off();
        int i;
        write_offset(16'($urandom));
        tx_idle_on = 1'b0;
        rx_hold_cycles = HOLD_OFF_CYCLES;
        for (i = 0; i < 30; i++) begin
            send_reading(random_reading());
        end
        tx_idle_on = idle_allowed;
    endtask

    // Random reads with runs of one code so the window settles on it.
    task automatic test_random_phase(input logic signed [SAMPLE_W-1:0] offset,
                                     input int count);
        t_item rd;
        int    run_left;
        int    i;
        write_offset(offset);
        run_left = 0;
        for (i = 0; i < count; i++) begin
            if (idle_allowed && i % 60 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (run_left > 0) begin
                run_left--;
            end else begin
                rd = random_reading();
                if ($urandom_range(0, 24) == 0) begin
                    rd.read_failed = 1'b0;
                    run_left = $urandom_range(WINDOW, WINDOW + 8);
                end
            end
            send_reading(rd);
        end
    endtask

    // Receiver side: random stall bursts and the long hold-off on request.
    initial begin
        int n;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                out_stall <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 6);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge clk) begin
        t_reading_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("result with nothing expected", current_value, 0);
            end else begin
                want = expected_readings.pop_front();
                if (current_value !== want.value) begin
                    report_mismatch("current_value", current_value, want.value);
                end
                if (error_flag !== want.err) begin
                    report_mismatch("error_flag", error_flag, want.err);
                end
            end
        end
    end

    // Test sequence.
    initial begin
        int i;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        code_high   <= '0;
        code_low    <= '0;
        read_failed <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        for (i = 0; i < WINDOW; i++) begin
            sample_history[i] = '0;
        end
        window_total = 0;
        oldest_slot  = '0;
        held_sample  = '0;
        cal_offset   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_failed_read_before_samples();
        test_code_extremes();
        test_output_hold_off();
        test_random_phase(16'sd0, 180);
        test_random_phase(16'sh7FFF, 180);
        test_random_phase(16'sh8000, 180);
        test_random_phase(16'($urandom), 180);

        // The last part runs with no idling on either side.
        idle_allowed = 1'b0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_phase(16'($urandom), 180);
        drain_results();

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* adc_current_moving_average_unit.f */
design/acma_pkg.sv
design/acma_in_reg.sv
design/acma_core.sv
design/adc_current_moving_average_unit.sv
sim/tb_adc_current_moving_average_unit.sv
